### sv/utrb_pkg.sv
package utrb_pkg;

  localparam int DATA_W      = 8;
  localparam int FUNC_W      = 2;
  localparam int OUT_TDATA_W = 16;

  localparam int OUT_VALID_BIT   = DATA_W;
  localparam int OUT_START_BIT   = DATA_W + 1;
  localparam int OUT_RUNNING_BIT = DATA_W + 2;
  localparam int OUT_PAD_W       = OUT_TDATA_W - DATA_W - 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TX_PUSH  = 2'd0,
    FUNC_RX_PUSH  = 2'd1,
    FUNC_TX_READY = 2'd2,
    FUNC_RX_POP   = 2'd3
  } func_t;

  typedef logic [DATA_W-1:0] byte_t;

endpackage

### sv/uart_tx_rx_ring_buffers_unit.sv
// channel  direction  tdata (low bit up)                             tuser
// in_      slave      data[7:0]                                      func[1:0]
// out_     master     out_byte[7:0] out_valid start_pulse tx_running  -
//                     and five zero bits
//
// one transaction per cycle unless stalled; results show the cycle after accept
// each ring is a memory with at most one write and one registered read per accept
// rst_n clears the ring positions, the running flag and out_tvalid;
// ring contents stay undefined until written
// a stalled result holds; input is taken when the result slot is free or emptying
module uart_tx_rx_ring_buffers_unit #(
  parameter int TX_DEPTH = 64,
  parameter int RX_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [utrb_pkg::DATA_W-1:0]         in_tdata,   // data[7:0]
  input  logic [utrb_pkg::FUNC_W-1:0]         in_tuser,   // func[1:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_byte[7:0], out_valid[8], start_pulse[9], tx_running[10], zero[15:11]
  output logic [utrb_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);

  utrb_pkg::byte_t tx_mem [TX_DEPTH];
  utrb_pkg::byte_t rx_mem [RX_DEPTH];
  utrb_pkg::byte_t tx_q_r;
  utrb_pkg::byte_t rx_q_r;

  logic [TX_AW-1:0] tx_wr_r, tx_wr_nxt, tx_rd_r, tx_rd_nxt;
  logic [RX_AW-1:0] rx_wr_r, rx_wr_nxt, rx_rd_r, rx_rd_nxt;
  logic             running_r, running_nxt;
  logic             out_tvalid_r;
  logic             res_valid_r, res_valid_nxt;
  logic             start_r, start_nxt;
  logic             sel_rx_r;

  logic             accept;
  utrb_pkg::func_t  func;
  logic             tx_empty, rx_empty;

  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign func      = utrb_pkg::func_t'(in_tuser);
  assign tx_empty  = (tx_wr_r == tx_rd_r);
  assign rx_empty  = (rx_wr_r == rx_rd_r);

  always_comb begin
    tx_wr_nxt     = tx_wr_r;
    tx_rd_nxt     = tx_rd_r;
    rx_wr_nxt     = rx_wr_r;
    rx_rd_nxt     = rx_rd_r;
    running_nxt   = running_r;
    res_valid_nxt = 1'b0;
    start_nxt     = 1'b0;
    unique case (func)
      utrb_pkg::FUNC_TX_PUSH: begin
        tx_wr_nxt   = (tx_wr_r == TX_LAST) ? '0 : tx_wr_r + TX_AW'(1);
        running_nxt = 1'b1;
        start_nxt   = !running_r;
      end
      utrb_pkg::FUNC_RX_PUSH: begin
        rx_wr_nxt = (rx_wr_r == RX_LAST) ? '0 : rx_wr_r + RX_AW'(1);
      end
      utrb_pkg::FUNC_TX_READY: begin
        if (tx_empty) begin
          running_nxt = 1'b0;
        end else begin
          res_valid_nxt = 1'b1;
          tx_rd_nxt     = (tx_rd_r == TX_LAST) ? '0 : tx_rd_r + TX_AW'(1);
        end
      end
      utrb_pkg::FUNC_RX_POP: begin
        if (!rx_empty) begin
          res_valid_nxt = 1'b1;
          rx_rd_nxt     = (rx_rd_r == RX_LAST) ? '0 : rx_rd_r + RX_AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wr_r      <= '0;
      tx_rd_r      <= '0;
      rx_wr_r      <= '0;
      rx_rd_r      <= '0;
      running_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (accept) begin
        tx_wr_r   <= tx_wr_nxt;
        tx_rd_r   <= tx_rd_nxt;
        rx_wr_r   <= rx_wr_nxt;
        rx_rd_r   <= rx_rd_nxt;
        running_r <= running_nxt;
      end
      if (accept) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_valid_r <= res_valid_nxt;
      start_r     <= start_nxt;
      sel_rx_r    <= (func == utrb_pkg::FUNC_RX_POP);
    end
  end

  // tx ring storage
  always_ff @(posedge clk) begin
    if (accept && func == utrb_pkg::FUNC_TX_PUSH) begin
      tx_mem[tx_wr_r] <= in_tdata;
    end
    if (accept) begin
      tx_q_r <= tx_mem[tx_rd_r];
    end
  end

  // rx ring storage
  always_ff @(posedge clk) begin
    if (accept && func == utrb_pkg::FUNC_RX_PUSH) begin
      rx_mem[rx_wr_r] <= in_tdata;
    end
    if (accept) begin
      rx_q_r <= rx_mem[rx_rd_r];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{utrb_pkg::OUT_PAD_W{1'b0}}, running_r, start_r, res_valid_r,
                       res_valid_r ? (sel_rx_r ? rx_q_r : tx_q_r) : utrb_pkg::byte_t'(0)};

endmodule

### sv/utrb_checker.sv
module utrb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [utrb_pkg::FUNC_W-1:0]      in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [utrb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a result without a valid byte, as from an empty ring, gives a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[utrb_pkg::OUT_VALID_BIT]
      |-> out_tdata[utrb_pkg::DATA_W-1:0] == '0)
    else $error("byte not zero without valid");

  // a start pulse leaves the transmitter running
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[utrb_pkg::OUT_START_BIT]
      |-> out_tdata[utrb_pkg::OUT_RUNNING_BIT])
    else $error("start pulse without running flag");

  // an accepted tx push is reported with the running flag set
  a_push_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == utrb_pkg::FUNC_TX_PUSH
      |=> out_tvalid && out_tdata[utrb_pkg::OUT_RUNNING_BIT]
          && !out_tdata[utrb_pkg::OUT_VALID_BIT])
    else $error("tx push result wrong");

  // reset empties the result slot
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind uart_tx_rx_ring_buffers_unit utrb_checker u_utrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int TX_DEPTH       = 64;
  localparam int RX_DEPTH       = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    utrb_pkg::byte_t octet;
    logic            present;
    logic            kick;
    logic            busy;
  } ring_result_t;

  logic                             clk;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [utrb_pkg::DATA_W-1:0]      in_tdata   = '0;
  logic [utrb_pkg::FUNC_W-1:0]      in_tuser   = utrb_pkg::FUNC_TX_PUSH;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [utrb_pkg::OUT_TDATA_W-1:0] out_tdata;

  // predictor state
  utrb_pkg::byte_t tx_mem [TX_DEPTH];
  utrb_pkg::byte_t rx_mem [RX_DEPTH];
  int    tx_wr, tx_rd, rx_wr, rx_rd;
  logic  tx_busy;

  ring_result_t expected_q [$];
  int fail_cnt     = 0;
  int items_sent   = 0;
  int quiet_cycles = 0;
  int in_idle_pct  = 0;
  int out_stall_pct = 0;
  int hold_req     = 0;
  int hold_left    = 0;

  uart_tx_rx_ring_buffers_unit #(
    .TX_DEPTH(TX_DEPTH),
    .RX_DEPTH(RX_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int step_pos(int pos, int depth);
    return (pos + 1 >= depth) ? 0 : pos + 1;
  endfunction

  function automatic ring_result_t predict_ring(utrb_pkg::func_t f, utrb_pkg::byte_t d);
    ring_result_t r;
    r = '0;
    case (f)
      utrb_pkg::FUNC_TX_PUSH: begin
        tx_mem[tx_wr] = d;
        tx_wr = step_pos(tx_wr, TX_DEPTH);
        if (!tx_busy) begin
          tx_busy = 1'b1;
          r.kick = 1'b1;
        end
      end
      utrb_pkg::FUNC_RX_PUSH: begin
        rx_mem[rx_wr] = d;
        rx_wr = step_pos(rx_wr, RX_DEPTH);
      end
      utrb_pkg::FUNC_TX_READY: begin
        if (tx_wr != tx_rd) begin
          r.octet = tx_mem[tx_rd];
          r.present = 1'b1;
          tx_rd = step_pos(tx_rd, TX_DEPTH);
        end else begin
          tx_busy = 1'b0;
        end
      end
      default: begin
        if (rx_wr != rx_rd) begin
          r.octet = rx_mem[rx_rd];
          r.present = 1'b1;
          rx_rd = step_pos(rx_rd, RX_DEPTH);
        end
      end
    endcase
    r.busy = tx_busy;
    return r;
  endfunction

  task automatic send_item(utrb_pkg::func_t f, utrb_pkg::byte_t d);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_ring(f, d));
    items_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(int in_pct, int out_pct);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
  endtask

  // receiver side
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    ring_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction, out_tdata %0h", out_tdata);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[utrb_pkg::DATA_W-1:0] !== want.octet) begin
          $error("out_byte: expected %0h, got %0h", want.octet,
                 out_tdata[utrb_pkg::DATA_W-1:0]);
          fail_cnt++;
        end
        if (out_tdata[utrb_pkg::OUT_VALID_BIT] !== want.present) begin
          $error("out_valid: expected %0b, got %0b", want.present,
                 out_tdata[utrb_pkg::OUT_VALID_BIT]);
          fail_cnt++;
        end
        if (out_tdata[utrb_pkg::OUT_START_BIT] !== want.kick) begin
          $error("start_pulse: expected %0b, got %0b", want.kick,
                 out_tdata[utrb_pkg::OUT_START_BIT]);
          fail_cnt++;
        end
        if (out_tdata[utrb_pkg::OUT_RUNNING_BIT] !== want.busy) begin
          $error("tx_running: expected %0b, got %0b", want.busy,
                 out_tdata[utrb_pkg::OUT_RUNNING_BIT]);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ready on an idle transmitter and pop from an empty ring
  task automatic test_empty_after_reset;
    send_item(utrb_pkg::FUNC_TX_READY, 8'hFF);
    send_item(utrb_pkg::FUNC_RX_POP, 8'h00);
    drain();
  endtask

  task automatic test_tx_path;
    send_item(utrb_pkg::FUNC_TX_PUSH, 8'h00);
    send_item(utrb_pkg::FUNC_TX_PUSH, 8'hFF);
    send_item(utrb_pkg::FUNC_TX_PUSH, 8'hA5);
    send_item(utrb_pkg::FUNC_TX_READY, 8'hFF);
    send_item(utrb_pkg::FUNC_TX_READY, 8'h00);
    send_item(utrb_pkg::FUNC_TX_READY, 8'h5A);
    // empty ring clears the running flag
    send_item(utrb_pkg::FUNC_TX_READY, 8'hFF);
    send_item(utrb_pkg::FUNC_TX_PUSH, 8'h3C);
    send_item(utrb_pkg::FUNC_TX_READY, 8'h00);
    send_item(utrb_pkg::FUNC_TX_READY, 8'h00);
    drain();
  endtask

  task automatic test_rx_path;
    send_item(utrb_pkg::FUNC_RX_PUSH, 8'h00);
    send_item(utrb_pkg::FUNC_RX_PUSH, 8'hFF);
    send_item(utrb_pkg::FUNC_RX_PUSH, 8'h81);
    send_item(utrb_pkg::FUNC_RX_POP, 8'hFF);
    send_item(utrb_pkg::FUNC_RX_POP, 8'h00);
    send_item(utrb_pkg::FUNC_RX_POP, 8'h7E);
    send_item(utrb_pkg::FUNC_RX_POP, 8'hFF);
    send_item(utrb_pkg::FUNC_RX_POP, 8'h00);
    drain();
  endtask

  // a full ring of pushes wraps onto the read position and looks empty
  task automatic test_ring_overflow;
    repeat (TX_DEPTH) send_item(utrb_pkg::FUNC_TX_PUSH, utrb_pkg::byte_t'($urandom));
    send_item(utrb_pkg::FUNC_TX_READY, 8'h00);
    repeat (TX_DEPTH + 1) send_item(utrb_pkg::FUNC_TX_PUSH, utrb_pkg::byte_t'($urandom));
    send_item(utrb_pkg::FUNC_TX_READY, 8'h00);
    send_item(utrb_pkg::FUNC_TX_READY, 8'h00);
    repeat (RX_DEPTH + 1) send_item(utrb_pkg::FUNC_RX_PUSH, utrb_pkg::byte_t'($urandom));
    send_item(utrb_pkg::FUNC_RX_POP, 8'h00);
    send_item(utrb_pkg::FUNC_RX_POP, 8'h00);
    drain();
  endtask

  task automatic test_random_traffic(int n_items);
    int              stop_at;
    int              burst;
    utrb_pkg::func_t put_f;
    utrb_pkg::func_t get_f;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 7) begin
        burst = ($urandom_range(15) == 0) ? $urandom_range(50, 70) : $urandom_range(1, 16);
        if ($urandom_range(1) == 1) begin
          put_f = utrb_pkg::FUNC_TX_PUSH;
          get_f = utrb_pkg::FUNC_TX_READY;
        end else begin
          put_f = utrb_pkg::FUNC_RX_PUSH;
          get_f = utrb_pkg::FUNC_RX_POP;
        end
        repeat (burst) send_item(put_f, utrb_pkg::byte_t'($urandom));
        repeat ($urandom_range(burst + 2, burst)) send_item(get_f, utrb_pkg::byte_t'($urandom));
      end else begin
        send_item(utrb_pkg::func_t'($urandom_range(3)), utrb_pkg::byte_t'($urandom));
      end
    end
    drain();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure_fill;
    set_idling(0, 0);
    hold_req = HOLD_CYCLES;
    repeat (20) begin
      send_item(utrb_pkg::FUNC_TX_PUSH, utrb_pkg::byte_t'($urandom));
      send_item(utrb_pkg::FUNC_RX_PUSH, utrb_pkg::byte_t'($urandom));
    end
    repeat (22) begin
      send_item(utrb_pkg::FUNC_TX_READY, utrb_pkg::byte_t'($urandom));
      send_item(utrb_pkg::FUNC_RX_POP, utrb_pkg::byte_t'($urandom));
    end
    drain();
  endtask

  initial begin
    tx_wr   = 0;
    tx_rd   = 0;
    rx_wr   = 0;
    rx_rd   = 0;
    tx_busy = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0, 0);
    test_empty_after_reset();
    test_tx_path();
    test_rx_path();
    set_idling(24, 24);
    test_ring_overflow();

    set_idling(0, 0);
    test_random_traffic(255);
    set_idling(86, 0);
    test_random_traffic(255);
    set_idling(0, 86);
    test_random_traffic(255);
    set_idling(24, 24);
    test_random_traffic(255);

    test_backpressure_fill();

    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
sv/utrb_pkg.sv
sv/uart_tx_rx_ring_buffers_unit.sv
sv/utrb_checker.sv
bench/tb.sv
